// ===== design/kdrt_pkg.sv =====
// Package for key_debounce_and_reply_timeouts: item codes, field widths,
// reset constants and the vertical-counter debounce step.
// No dependencies.
package kdrt_pkg;

  localparam int unsigned CHANNELS_DEF   = 13;
  localparam int unsigned PORT_W         = 8;
  localparam int unsigned CHAN_W         = 4;
  localparam int unsigned TOUT_W         = 16;
  localparam int unsigned FUNC_W         = 3;
  localparam int unsigned IN_DATA_W      = 32;
  localparam int unsigned OUT_DATA_W     = 32;
  localparam logic [TOUT_W-1:0] RELOAD_RST = 16'd600;
  localparam logic [PORT_W-1:0] COUNT_RST  = 8'hFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 3'd0,
    FUNC_READ  = 3'd1,
    FUNC_ARM   = 3'd2,
    FUNC_CLEAR = 3'd3,
    FUNC_TAKE  = 3'd4
  } func_t;

  typedef struct packed {
    logic [PORT_W-1:0] level;
    logic [PORT_W-1:0] cnt_lo;
    logic [PORT_W-1:0] cnt_hi;
    logic [PORT_W-1:0] press;
  } deb_t;

  function automatic deb_t deb_step(input logic [PORT_W-1:0] pins,
                                    input deb_t cur);
    deb_t              res;
    logic [PORT_W-1:0] delta;
    logic [PORT_W-1:0] flip;
    delta      = ~pins ^ cur.level;
    res.cnt_lo = ~(cur.cnt_lo & delta);
    res.cnt_hi = res.cnt_lo ^ (cur.cnt_hi & delta);
    flip       = delta & res.cnt_lo & res.cnt_hi;
    res.level  = cur.level ^ flip;
    res.press  = cur.press | (res.level & flip);
    return res;
  endfunction

endpackage

// ===== design/key_debounce_and_reply_timeouts.sv =====
// Top level: two-port key debounce with sticky press flags and per-channel
// reply timeouts. Depends on kdrt_pkg.
//
//  channel | ports                           | transfer carries
//  --------+---------------------------------+-------------------------------
//  in      | in_tvalid/in_tready/in_tdata/   | command, pin samples, selects
//          | in_tuser                        |
//  out     | out_tvalid/out_tready/out_tdata | press bits, expired, levels
//  cfg     | cfg_wr_en/cfg_wr_data           | timeout reload value
//
// State and result update at the accepting edge.
// Result sits in an output register backed by one skid entry; in_tready
// drops only while the skid entry is full.
// Reset (synchronous, rst_n low) clears levels, press flags, timeouts,
// expired flags and both valid bits; reload returns to 600.
module key_debounce_and_reply_timeouts #(
  parameter int unsigned CHANNELS = kdrt_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [kdrt_pkg::TOUT_W-1:0]         cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] pins_d, [15:8] pins_c, [16] port_select, [24:17] press_mask,
  // [28:25] channel, [31:29] zero
  input  logic [kdrt_pkg::IN_DATA_W-1:0]      in_tdata,
  // [2:0] func
  input  logic [kdrt_pkg::FUNC_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] press_bits, [8] expired, [16:9] level_d, [24:17] level_c,
  // [31:25] zero
  output logic [kdrt_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import kdrt_pkg::*;

  logic [TOUT_W-1:0]   reload_r;
  deb_t                deb_d_r, deb_d_nxt;
  deb_t                deb_c_r, deb_c_nxt;
  logic [TOUT_W-1:0]   cnt_r   [CHANNELS];
  logic [TOUT_W-1:0]   cnt_nxt [CHANNELS];
  logic [CHANNELS-1:0] flags_r, flags_nxt;
  logic [CHANNELS-1:0] chan_hit;

  logic                out_valid_r, skid_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, skid_data_r;
  logic [OUT_DATA_W-1:0] res_data;

  func_t               func;
  logic [PORT_W-1:0]   pins_d, pins_c, press_mask, press_bits;
  logic                port_sel, expired;
  logic [CHAN_W-1:0]   chan;
  logic                acc;

  assign func       = func_t'(in_tuser);
  assign pins_d     = in_tdata[7:0];
  assign pins_c     = in_tdata[15:8];
  assign port_sel   = in_tdata[16];
  assign press_mask = in_tdata[24:17];
  assign chan       = in_tdata[28:25];

  assign in_tready  = ~skid_valid_r;
  assign acc        = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      chan_hit[k] = ({28'd0, chan} == 32'(k));
    end
  end

  always_comb begin
    deb_d_nxt  = deb_d_r;
    deb_c_nxt  = deb_c_r;
    flags_nxt  = flags_r;
    press_bits = '0;
    expired    = 1'b0;
    for (int k = 0; k < CHANNELS; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end
    case (func)
      FUNC_TICK: begin
        for (int k = 0; k < CHANNELS; k++) begin
          if (cnt_r[k] != '0) begin
            cnt_nxt[k] = cnt_r[k] - 1'b1;
            if (cnt_r[k] == TOUT_W'(1)) begin
              flags_nxt[k] = 1'b1;
            end
          end
        end
        deb_d_nxt = deb_step(pins_d, deb_d_r);
        deb_c_nxt = deb_step(pins_c, deb_c_r);
      end
      FUNC_READ: begin
        if (!port_sel) begin
          press_bits      = press_mask & deb_d_r.press;
          deb_d_nxt.press = deb_d_r.press ^ press_bits;
        end else begin
          press_bits      = press_mask & deb_c_r.press;
          deb_c_nxt.press = deb_c_r.press ^ press_bits;
        end
      end
      FUNC_ARM: begin
        for (int k = 0; k < CHANNELS; k++) begin
          if (chan_hit[k]) begin
            cnt_nxt[k] = reload_r;
          end
        end
      end
      FUNC_CLEAR: begin
        for (int k = 0; k < CHANNELS; k++) begin
          cnt_nxt[k] = '0;
        end
      end
      FUNC_TAKE: begin
        expired   = |(flags_r & chan_hit);
        flags_nxt = flags_r & ~chan_hit;
      end
      default: begin
      end
    endcase
    res_data = {7'd0, deb_c_nxt.level, deb_d_nxt.level, expired, press_bits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= RELOAD_RST;
    end else if (cfg_wr_en) begin
      reload_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_d_r <= '{level: '0, cnt_lo: COUNT_RST, cnt_hi: COUNT_RST, press: '0};
      deb_c_r <= '{level: '0, cnt_lo: COUNT_RST, cnt_hi: COUNT_RST, press: '0};
      flags_r <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (acc) begin
      deb_d_r <= deb_d_nxt;
      deb_c_r <= deb_c_nxt;
      flags_r <= flags_nxt;
      for (int k = 0; k < CHANNELS; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r | acc;
      skid_valid_r <= 1'b0;
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_data;
    end else if (acc) begin
      skid_data_r <= res_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_flags_rise_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(acc && func == FUNC_TICK)) |=> ((flags_r & ~$past(flags_r)) == '0))
    else $error("expired flag set outside a tick");

  a_level_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(acc && func == FUNC_TICK)) |=>
      ($stable(deb_d_r.level) && $stable(deb_c_r.level)))
    else $error("debounced level changed outside a tick");

  a_read_clears_d: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && acc && func == FUNC_READ && !port_sel) |=>
      ((deb_d_r.press & $past(press_mask)) == '0))
    else $error("press flags not cleared by read");

endmodule

// ===== test/tb_key_debounce_and_reply_timeouts.sv =====
`timescale 1ns / 100ps
// Testbench for key_debounce_and_reply_timeouts: streams command transfers with random gaps
// and output stalls, predicts every reply in a scoreboard class and checks it field by field.
// Depends on kdrt_pkg and the key_debounce_and_reply_timeouts top level.
module tb_key_debounce_and_reply_timeouts;
  import kdrt_pkg::*;

  localparam int NUM_CHANNELS = CHANNELS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd5;
  localparam int RAND_ITEMS = 850;
  localparam int PHASES = 8;
  localparam int LIMIT_NS = 10_000_000;

  typedef struct {
    logic [PORT_W-1:0] press_bits;
    logic              expired;
    logic [PORT_W-1:0] level_d;
    logic [PORT_W-1:0] level_c;
  } reply_t;

  class key_tracker;
    logic [TOUT_W-1:0]       reload;
    logic [PORT_W-1:0]       level[2];
    logic [PORT_W-1:0]       cnt_lo[2];
    logic [PORT_W-1:0]       cnt_hi[2];
    logic [PORT_W-1:0]       press[2];
    logic [TOUT_W-1:0]       countdown[NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] expired_flags;
    reply_t                  replies_due[$];
    int                      errors;

    function new();
      reload = RELOAD_RST;
      for (int p = 0; p < 2; p++) begin
        level[p]  = '0;
        cnt_lo[p] = COUNT_RST;
        cnt_hi[p] = COUNT_RST;
        press[p]  = '0;
      end
      foreach (countdown[k]) countdown[k] = '0;
      expired_flags = '0;
      errors = 0;
    endfunction

    // advance one port's 2-bit vertical counters; a bit flips on the fourth differing tick
    function void debounce_port(int p, logic [PORT_W-1:0] raw);
      logic [PORT_W-1:0] differ;
      logic [PORT_W-1:0] flip;
      differ    = ~raw ^ level[p];
      cnt_lo[p] = ~(cnt_lo[p] & differ);
      cnt_hi[p] = cnt_lo[p] ^ (cnt_hi[p] & differ);
      flip      = differ & cnt_lo[p] & cnt_hi[p];
      level[p]  = level[p] ^ flip;
      press[p]  = press[p] | (level[p] & flip);
    endfunction

    function void note_transfer(logic [FUNC_W-1:0] fn, logic [IN_DATA_W-1:0] data);
      reply_t            r;
      logic              sel;
      logic [PORT_W-1:0] mask;
      logic [CHAN_W-1:0] ch;
      sel  = data[16];
      mask = data[24:17];
      ch   = data[28:25];
      r.press_bits = '0;
      r.expired    = 1'b0;
      case (fn)
        FUNC_TICK: begin
          foreach (countdown[k]) begin
            if (countdown[k] != 0) begin
              countdown[k] = countdown[k] - 1'b1;
              if (countdown[k] == 0) expired_flags[k] = 1'b1;
            end
          end
          debounce_port(0, data[7:0]);
          debounce_port(1, data[15:8]);
        end
        FUNC_READ: begin
          r.press_bits = mask & press[sel];
          press[sel]   = press[sel] & ~r.press_bits;
        end
        FUNC_ARM: begin
          if (ch < NUM_CHANNELS) countdown[ch] = reload;
        end
        FUNC_CLEAR: begin
          foreach (countdown[k]) countdown[k] = '0;
        end
        FUNC_TAKE: begin
          if (ch < NUM_CHANNELS) begin
            r.expired         = expired_flags[ch];
            expired_flags[ch] = 1'b0;
          end
        end
        default: begin
        end
      endcase
      r.level_d = level[0];
      r.level_c = level[1];
      replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [PORT_W-1:0] want, logic [PORT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] d);
      reply_t want;
      if (replies_due.size() == 0) begin
        $error("reply %h with no command pending", d);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      compare_field("press_bits", want.press_bits, d[7:0]);
      compare_field("expired", {7'b0, want.expired}, {7'b0, d[8]});
      compare_field("level_d", want.level_d, d[16:9]);
      compare_field("level_c", want.level_c, d[24:17]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [TOUT_W-1:0]     cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  bit                    calm;
  logic [PORT_W-1:0]     held_d;
  logic [PORT_W-1:0]     held_c;
  key_tracker            tracker = new();

  key_debounce_and_reply_timeouts dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_cmd(logic [PORT_W-1:0] pd, logic [PORT_W-1:0] pc,
                                                    logic sel, logic [PORT_W-1:0] mask,
                                                    logic [CHAN_W-1:0] ch);
    return {3'b000, ch, mask, sel, pc, pd};
  endfunction

  task automatic put(input logic [FUNC_W-1:0] fn, input logic [IN_DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic put_random();
    int                r;
    logic [PORT_W-1:0] pd;
    logic [PORT_W-1:0] pc;
    logic [PORT_W-1:0] mask;
    logic [CHAN_W-1:0] ch;
    logic [FUNC_W-1:0] fn;
    r    = $urandom_range(99);
    pd   = 8'($urandom);
    pc   = 8'($urandom);
    mask = 8'($urandom);
    if ($urandom_range(6) == 0) ch = 4'($urandom_range(15, NUM_CHANNELS));
    else ch = 4'($urandom_range(NUM_CHANNELS - 1));
    if (r < 50) begin
      fn = FUNC_TICK;
      if ($urandom_range(7) == 0) held_d = held_d ^ 8'(1 << $urandom_range(7));
      if ($urandom_range(7) == 0) held_c = held_c ^ 8'(1 << $urandom_range(7));
      pd = held_d;
      pc = held_c;
      if ($urandom_range(9) == 0) pd = pd ^ (8'($urandom) & 8'($urandom));
      if ($urandom_range(9) == 0) pc = pc ^ (8'($urandom) & 8'($urandom));
    end else if (r < 63) begin
      fn = FUNC_READ;
      if ($urandom_range(1) == 0) mask = 8'hFF;
    end else if (r < 78) begin
      fn = FUNC_ARM;
    end else if (r < 82) begin
      fn = FUNC_CLEAR;
    end else if (r < 97) begin
      fn = FUNC_TAKE;
    end else begin
      fn = FUNC_SPARE + 3'($urandom_range(2));
    end
    put(fn, pack_cmd(pd, pc, 1'($urandom), mask, ch));
  endtask

  task automatic drain_replies();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.replies_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reload(input logic [TOUT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    tracker.reload = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_reply(out_tdata);
      if (in_tvalid && in_tready) tracker.note_transfer(in_tuser, in_tdata);
    end
  end

  initial begin
    int run;
    out_tready = 1'b0;
    forever begin
      run = $urandom_range(12, 1);
      @(negedge clk);
      out_tready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      run = pick_gap();
      if (run > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  initial begin
    logic [TOUT_W-1:0] reload_plan[PHASES];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    calm        = 1'b1;
    held_d      = 8'hFF;
    held_c      = 8'hFF;
    reload_plan = '{16'd2, 16'hFFFF, 16'd1, 16'd0, 16'd3, 16'd5, RELOAD_RST, 16'd7};
    reload_plan[5] = 16'($urandom_range(30, 4));
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // press everything on both ports, then read the press flags back
    put(FUNC_TICK, pack_cmd(8'hFF, 8'hFF, 1'b0, 8'h00, 4'd0));
    repeat (4) put(FUNC_TICK, pack_cmd(8'h00, 8'h00, 1'b1, 8'hFF, 4'hF));
    put(FUNC_READ, pack_cmd(8'hA5, 8'h5A, 1'b0, 8'hFF, 4'd0));
    put(FUNC_READ, pack_cmd(8'h00, 8'h00, 1'b1, 8'h0F, 4'd0));
    put(FUNC_READ, pack_cmd(8'h00, 8'h00, 1'b1, 8'hFF, 4'd0));
    put(FUNC_ARM, pack_cmd(8'h00, 8'h00, 1'b0, 8'h00, 4'd0));
    put(FUNC_ARM, pack_cmd(8'h00, 8'h00, 1'b0, 8'h00, 4'(NUM_CHANNELS - 1)));
    put(FUNC_ARM, pack_cmd(8'h00, 8'h00, 1'b0, 8'h00, 4'hF));
    put(FUNC_TICK, pack_cmd(8'hFF, 8'hFF, 1'b0, 8'h00, 4'd0));
    put(FUNC_TAKE, pack_cmd(8'h00, 8'h00, 1'b0, 8'h00, 4'd0));
    put(FUNC_TAKE, pack_cmd(8'h00, 8'h00, 1'b0, 8'h00, 4'(NUM_CHANNELS)));
    put(FUNC_CLEAR, pack_cmd(8'hFF, 8'hFF, 1'b1, 8'hFF, 4'hF));
    for (int k = 0; k < 3; k++) put(FUNC_SPARE + 3'(k), pack_cmd(8'hFF, 8'h00, 1'b1, 8'hFF, 4'd1));

    // one-tick reload: expire, take the sticky flag twice
    drain_replies();
    write_reload(16'd1);
    put(FUNC_ARM, pack_cmd(8'hFF, 8'hFF, 1'b0, 8'h00, 4'(NUM_CHANNELS - 1)));
    put(FUNC_TICK, pack_cmd(8'hFF, 8'hFF, 1'b0, 8'h00, 4'd0));
    put(FUNC_TAKE, pack_cmd(8'h00, 8'h00, 1'b0, 8'h00, 4'(NUM_CHANNELS - 1)));
    put(FUNC_TAKE, pack_cmd(8'h00, 8'h00, 1'b0, 8'h00, 4'(NUM_CHANNELS - 1)));

    // zero reload keeps the channel idle
    drain_replies();
    write_reload(16'd0);
    put(FUNC_ARM, pack_cmd(8'h00, 8'h00, 1'b0, 8'h00, 4'd3));
    put(FUNC_TICK, pack_cmd(8'hFF, 8'hFF, 1'b0, 8'h00, 4'd3));
    put(FUNC_TAKE, pack_cmd(8'h00, 8'h00, 1'b0, 8'h00, 4'd3));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_replies();
      write_reload(reload_plan[ph]);
      calm = (ph == 2 || ph == 5);
      for (int i = 0; i < RAND_ITEMS / PHASES; i++) put_random();
    end

    drain_replies();
    repeat (6) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("** key_debounce_and_reply_timeouts: PASSED **");
    end else begin
      $display("** key_debounce_and_reply_timeouts: FAILED **");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("** key_debounce_and_reply_timeouts: FAILED **");
    $finish;
  end

endmodule
